FILE: sv/lwc_pkg.sv
package lwc_pkg;

  localparam int ADDR_W      = 32;
  localparam int PF_COUNT_W  = 3;
  localparam int PF_BLOCK_W  = 27;
  localparam int BUF_USED_W  = 2;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

FILE: sv/lwc_ram.sv
module lwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/lru_writeback_cache_with_stream_prefetch_core.sv
// Set-associative write-back cache tag store with stream buffer prefetch.
// Input channel (in_valid / in_stall) carries one access: kind (0 read,
// 1 write) and a 32-bit byte address. Output channel (out_valid / out_stall)
// returns one result per access: cache and stream hit flags, demand fetch,
// dirty writeback address, and the run of blocks prefetched.
// Each access reads the set's row (tags, valid, dirty and LRU order of all
// ways) from the tag RAM in ST_IDLE, then evaluates and writes the row
// back in ST_LOOKUP. The read-modify-write of the single-port-per-side tag
// RAM sets the rate: a new access is taken only once the last has written back.
// The finished result sits in an output register; the next access is taken
// while it waits, but its write-back waits until the receiver takes the
// earlier transaction (out_stall low), holding in_stall high meanwhile.
// Reset (rst, synchronous) clears stream buffers and LRU order, sets
// prefetch_enable to 1, then sweeps the tag RAM one set per cycle, with
// in_stall high throughout the sweep. cfg_write / cfg_data set
// prefetch_enable at any time; write it only while the block is idle.
// SETS is taken as a power of two.
module lru_writeback_cache_with_stream_prefetch_core
  import lwc_pkg::*;
#(
  parameter int SETS           = 256,
  parameter int WAYS           = 4,
  parameter int OFFSET_BITS    = 5,
  parameter int STREAM_BUFFERS = 4,
  parameter int BUFFER_DEPTH   = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic [ADDR_W-1:0]     address,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  cache_hit,
  output logic                  stream_hit,
  output logic                  demand_fetch,
  output logic                  writeback_valid,
  output logic [ADDR_W-1:0]     writeback_address,
  output logic [PF_COUNT_W-1:0] prefetch_count,
  output logic [PF_BLOCK_W-1:0] prefetch_first_block,
  output logic [BUF_USED_W-1:0] stream_buffer_used
);

  localparam int IDX_BITS = $clog2(SETS);
  localparam int SET_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int BLK_W    = ADDR_W - OFFSET_BITS;
  localparam int TAG_W    = BLK_W - IDX_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SB_W     = (STREAM_BUFFERS > 1) ? $clog2(STREAM_BUFFERS) : 1;
  localparam int POS_W    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int FIELD_W  = TAG_W + 2;
  localparam int ROW_W    = WAYS * FIELD_W + WAYS * WAY_W;

  // per-way field: {valid, dirty, tag}
  typedef logic [WAYS-1:0][FIELD_W-1:0] ways_t;
  typedef logic [WAYS-1:0][WAY_W-1:0]   lru_t;

  state_t state, state_next;

  logic              prefetch_enable;
  logic [SET_W-1:0]  clear_cnt;
  logic              kind_q;
  logic [BLK_W-1:0]  block_q;

  logic [STREAM_BUFFERS-1:0]            stream_valid;
  logic [STREAM_BUFFERS-1:0][BLK_W-1:0] stream_base;
  logic [STREAM_BUFFERS-1:0][SB_W-1:0]  stream_order;

  logic             ram_we, ram_re;
  logic [SET_W-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  ways_t rd_ways, wr_ways;
  lru_t  rd_lru, wr_lru, clr_lru;

  logic [TAG_W-1:0] tag_q;
  logic [SET_W-1:0] set_q;
  logic             out_free, finish;

  // lookup results
  logic             hit, free_found, wb;
  logic [WAY_W-1:0] hit_way, free_way, victim, way_sel, way_pos;
  logic             shit, do_stream;
  logic [SB_W-1:0]  hit_buf, sel_buf, free_buf, buf_pos;
  logic             buf_free_found;
  logic [POS_W-1:0] hit_pos;
  logic [BLK_W-1:0] blk_delta;
  logic [BLK_W-1:0] next_block, pf_first;
  logic [31:0]      pf_count_w, pf_first_w, buf_w;
  logic [STREAM_BUFFERS-1:0][SB_W-1:0] order_next;

  lwc_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign {rd_lru, rd_ways} = ram_rdata;
  assign tag_q    = block_q[BLK_W-1 -: TAG_W];
  assign set_q    = (IDX_BITS > 0) ? SET_W'(block_q) : '0;
  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == ST_LOOKUP) && out_free;

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      clr_lru[j] = WAY_W'(WAYS - 1 - j);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clear_cnt == SET_W'(SETS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_LOOKUP;
      ST_LOOKUP: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = set_q;
    ram_wdata = {wr_lru, wr_ways};
    ram_raddr = (IDX_BITS > 0) ? SET_W'(address >> OFFSET_BITS) : '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_cnt;
        ram_wdata = {clr_lru, ways_t'('0)};
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        ram_re   = in_valid;
      end
      ST_LOOKUP: begin
        ram_we = out_free;
      end
      default: ;
    endcase
  end

  // cache lookup, victim choice and LRU update
  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit && rd_ways[i][FIELD_W-1] && rd_ways[i][TAG_W-1:0] == tag_q) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!free_found && !rd_ways[i][FIELD_W-1]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(i);
      end
    end
    victim  = rd_lru[WAYS-1];
    way_sel = hit ? hit_way : (free_found ? free_way : victim);
    wb      = !hit && !free_found && rd_ways[victim][FIELD_W-2];

    wr_ways = rd_ways;
    if (hit) begin
      wr_ways[way_sel][FIELD_W-2] = rd_ways[way_sel][FIELD_W-2] | (kind_q == KIND_WRITE);
    end else begin
      wr_ways[way_sel] = {1'b1, kind_q, tag_q};
    end

    way_pos = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (rd_lru[i] == way_sel) way_pos = WAY_W'(i);
    end
    wr_lru[0] = way_sel;
    for (int i = 1; i < WAYS; i++) begin
      wr_lru[i] = (WAY_W'(i) <= way_pos) ? rd_lru[i-1] : rd_lru[i];
    end
  end

  // stream buffer search, MRU first
  always_comb begin
    shit      = 1'b0;
    hit_buf   = '0;
    hit_pos   = '0;
    blk_delta = '0;
    for (int i = 0; i < STREAM_BUFFERS; i++) begin
      blk_delta = block_q - stream_base[stream_order[i]];
      if (!shit && stream_valid[stream_order[i]] && blk_delta < BLK_W'(BUFFER_DEPTH)) begin
        shit    = 1'b1;
        hit_buf = stream_order[i];
        hit_pos = POS_W'(blk_delta);
      end
    end
    buf_free_found = 1'b0;
    free_buf       = stream_order[STREAM_BUFFERS-1];
    for (int i = 0; i < STREAM_BUFFERS; i++) begin
      if (!buf_free_found && !stream_valid[i]) begin
        buf_free_found = 1'b1;
        free_buf       = SB_W'(i);
      end
    end
    do_stream  = prefetch_enable && (shit || !hit);
    sel_buf    = shit ? hit_buf : free_buf;
    next_block = block_q + BLK_W'(1);
    pf_first   = shit ? (block_q + BLK_W'(BUFFER_DEPTH) - BLK_W'(hit_pos)) : next_block;
    pf_count_w = shit ? (32'(hit_pos) + 32'd1) : 32'(BUFFER_DEPTH);
    pf_first_w = 32'(pf_first);
    buf_w      = 32'(sel_buf);

    buf_pos = '0;
    for (int i = STREAM_BUFFERS - 1; i >= 0; i--) begin
      if (stream_order[i] == sel_buf) buf_pos = SB_W'(i);
    end
    order_next[0] = sel_buf;
    for (int i = 1; i < STREAM_BUFFERS; i++) begin
      order_next[i] = (SB_W'(i) <= buf_pos) ? stream_order[i-1] : stream_order[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clear_cnt       <= '0;
      prefetch_enable <= 1'b1;
      out_valid       <= 1'b0;
      stream_valid    <= '0;
      for (int j = 0; j < STREAM_BUFFERS; j++) begin
        stream_order[j] <= SB_W'(STREAM_BUFFERS - 1 - j);
      end
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clear_cnt <= clear_cnt + SET_W'(1);
      if (cfg_write) prefetch_enable <= cfg_data;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (finish && do_stream) begin
        stream_valid[sel_buf] <= 1'b1;
        stream_order          <= order_next;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      kind_q  <= kind;
      block_q <= BLK_W'(address >> OFFSET_BITS);
    end
    if (finish && do_stream) begin
      stream_base[sel_buf] <= next_block;
    end
    if (finish) begin
      cache_hit            <= hit;
      stream_hit           <= prefetch_enable && shit;
      demand_fetch         <= !hit && !(prefetch_enable && shit);
      writeback_valid      <= wb;
      writeback_address    <= wb ? (ADDR_W'({rd_ways[victim][TAG_W-1:0], set_q[IDX_BITS > 0 ?
                                     SET_W-1 : 0 -: SET_W]}) >> (SET_W - IDX_BITS))
                                     << OFFSET_BITS : '0;
      prefetch_count       <= do_stream ? pf_count_w[PF_COUNT_W-1:0] : '0;
      prefetch_first_block <= do_stream ? pf_first_w[PF_BLOCK_W-1:0] : '0;
      stream_buffer_used   <= do_stream ? buf_w[BUF_USED_W-1:0] : '0;
    end
  end

endmodule

FILE: sim/tb_lru_writeback_cache_with_stream_prefetch_core.sv
`timescale 1ns / 1ps

module tb_lru_writeback_cache_with_stream_prefetch_core;
  import lwc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_ITEMS  = 650;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic        hit;
    logic        shit;
    logic        dfetch;
    logic        wbv;
    logic [31:0] wba;
    logic [2:0]  pfc;
    logic [26:0] pff;
    logic [1:0]  bufu;
  } access_res_t;

  typedef enum logic { ROW_ACCESS, ROW_CFG } row_op_e;

  typedef struct {
    row_op_e     op;
    logic        k;
    logic [31:0] a;
    bit          typed;
    access_res_t r;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0, cfg_data = 1'b0;
  logic in_valid = 1'b0, kind = 1'b0;
  logic [31:0] address = '0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid;
  logic cache_hit, stream_hit, demand_fetch, writeback_valid;
  logic [31:0] writeback_address;
  logic [2:0]  prefetch_count;
  logic [26:0] prefetch_first_block;
  logic [1:0]  stream_buffer_used;

  lru_writeback_cache_with_stream_prefetch_core dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .address(address),
    .out_valid(out_valid), .out_stall(out_stall), .cache_hit(cache_hit),
    .stream_hit(stream_hit), .demand_fetch(demand_fetch),
    .writeback_valid(writeback_valid), .writeback_address(writeback_address),
    .prefetch_count(prefetch_count), .prefetch_first_block(prefetch_first_block),
    .stream_buffer_used(stream_buffer_used)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow tag store and stream buffers
  logic            line_v [256][4];
  logic            line_d [256][4];
  logic [18:0]     line_t [256][4];
  logic [3:0][1:0] way_order [256];
  logic            strm_v [4];
  logic [26:0]     strm_base [4];
  logic [3:0][1:0] strm_order;
  logic            pf_on;

  access_res_t expected_q[$];
  int errors = 0, n_checked = 0, n_wb = 0, n_shit = 0, cycles = 0;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  logic rx_hold = 1'b0;
  bit hold_go = 0;

  function automatic logic [3:0][1:0] bump(logic [3:0][1:0] o, logic [1:0] id);
    int k;
    k = 0;
    for (int i = 3; i >= 0; i--) if (o[i] == id) k = i;
    for (int i = k; i > 0; i--) o[i] = o[i-1];
    o[0] = id;
    return o;
  endfunction

  function automatic access_res_t predict_access(logic k, logic [31:0] a);
    access_res_t r;
    logic [26:0] blk, d;
    logic [7:0]  s;
    logic [18:0] tg;
    int way, b;
    bit found;
    r = '0;
    blk = a[31:5];
    s = blk[7:0];
    tg = blk[26:8];
    way = 0;
    for (int i = 3; i >= 0; i--) if (line_v[s][i] && line_t[s][i] == tg) begin
      r.hit = 1'b1;
      way = i;
    end
    if (pf_on) begin
      for (int i = 0; i < 4 && !r.shit; i++) begin
        b = strm_order[i];
        d = blk - strm_base[b];
        if (strm_v[b] && d < 27'd4) begin
          r.shit = 1'b1;
          strm_base[b] = 27'(blk + 27'd1);
          strm_order = bump(strm_order, 2'(b));
          r.pfc = 3'(d + 27'd1);
          r.pff = 27'(blk + 27'd4 - d);
          r.bufu = 2'(b);
        end
      end
      if (!r.shit && !r.hit) begin
        b = strm_order[3];
        found = 0;
        for (int i = 0; i < 4; i++) if (!strm_v[i] && !found) begin
          b = i;
          found = 1;
        end
        strm_base[b] = 27'(blk + 27'd1);
        strm_v[b] = 1'b1;
        strm_order = bump(strm_order, 2'(b));
        r.pfc = 3'd4;
        r.pff = 27'(blk + 27'd1);
        r.bufu = 2'(b);
      end
    end
    if (r.hit) begin
      if (k == KIND_WRITE) line_d[s][way] = 1'b1;
    end else begin
      found = 0;
      for (int i = 0; i < 4; i++) if (!line_v[s][i] && !found) begin
        way = i;
        found = 1;
      end
      if (!found) begin
        way = way_order[s][3];
        if (line_d[s][way]) begin
          r.wbv = 1'b1;
          r.wba = {line_t[s][way], s, 5'b0};
        end
      end
      line_t[s][way] = tg;
      line_v[s][way] = 1'b1;
      line_d[s][way] = k;
    end
    way_order[s] = bump(way_order[s], 2'(way));
    r.dfetch = !r.hit && !r.shit;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("[%0t] mismatch on result %0d: %s got 0x%0h want 0x%0h",
             $time, n_checked, field, got, want);
  endtask

  always @(posedge clk) begin
    access_res_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("tb_lru_writeback_cache_with_stream_prefetch_core failed");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("[%0t] result with no access outstanding", $time);
      end else begin
        e = expected_q.pop_front();
        if (cache_hit !== e.hit)
          report_mismatch("cache_hit", 32'(cache_hit), 32'(e.hit));
        if (stream_hit !== e.shit)
          report_mismatch("stream_hit", 32'(stream_hit), 32'(e.shit));
        if (demand_fetch !== e.dfetch)
          report_mismatch("demand_fetch", 32'(demand_fetch), 32'(e.dfetch));
        if (writeback_valid !== e.wbv)
          report_mismatch("writeback_valid", 32'(writeback_valid), 32'(e.wbv));
        if (writeback_address !== e.wba)
          report_mismatch("writeback_address", writeback_address, e.wba);
        if (prefetch_count !== e.pfc)
          report_mismatch("prefetch_count", 32'(prefetch_count), 32'(e.pfc));
        if (prefetch_first_block !== e.pff)
          report_mismatch("prefetch_first_block", 32'(prefetch_first_block),
                          32'(e.pff));
        if (stream_buffer_used !== e.bufu)
          report_mismatch("stream_buffer_used", 32'(stream_buffer_used), 32'(e.bufu));
        if (e.wbv) n_wb++;
        if (e.shit) n_shit++;
        n_checked++;
      end
    end
  end

  always @(negedge clk)
    out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);

  // long receiver hold-off so the pipeline backs up into in_stall
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_access(logic k, logic [31:0] a, bit typed, access_res_t tr);
    access_res_t p;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    address <= a;
    do @(posedge clk); while (in_stall);
    p = predict_access(k, a);
    expected_q.insert(expected_q.size(), typed ? tr : p);
    @(negedge clk);
  endtask

  task automatic write_prefetch_enable(logic v);
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (4) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    pf_on = v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic stim_row_t acc(logic k, logic [31:0] a);
    stim_row_t r;
    r.op = ROW_ACCESS; r.k = k; r.a = a; r.typed = 0; r.r = '0;
    return r;
  endfunction

  function automatic stim_row_t acc_t(logic k, logic [31:0] a, access_res_t res);
    stim_row_t r;
    r = acc(k, a);
    r.typed = 1;
    r.r = res;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic v);
    stim_row_t r;
    r = acc(KIND_READ, '0);
    r.op = ROW_CFG;
    r.k = v;
    return r;
  endfunction

  initial begin
    stim_row_t rows[$];
    logic [31:0] strm_addr, a;
    logic [7:0] set_pool[4];
    logic [18:0] tg;
    int mode;

    for (int s = 0; s < 256; s++) begin
      way_order[s] = {2'd0, 2'd1, 2'd2, 2'd3};
      for (int w = 0; w < 4; w++) begin
        line_v[s][w] = 1'b0; line_d[s][w] = 1'b0; line_t[s][w] = '0;
      end
    end
    for (int i = 0; i < 4; i++) begin
      strm_v[i] = 1'b0;
      strm_base[i] = '0;
    end
    strm_order = {2'd0, 2'd1, 2'd2, 2'd3};
    pf_on = 1'b1;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    rows.insert(rows.size(), cfg_row(1'b1));
    rows.insert(rows.size(), acc_t(KIND_READ, 32'h0, '{0, 0, 1, 0, 0, 4, 1, 0}));
    rows.insert(rows.size(), acc_t(KIND_READ, 32'h20, '{0, 1, 0, 0, 0, 1, 5, 0}));
    rows.insert(rows.size(), acc_t(KIND_WRITE, 32'h0, '{1, 0, 0, 0, 0, 0, 0, 0}));
    // top block: buffer refill wraps to block 0
    rows.insert(rows.size(),
                acc_t(KIND_READ, 32'hFFFF_FFFF, '{0, 0, 1, 0, 0, 4, 0, 1}));
    // block 2 sits in two overlapping buffers; MRU one wins
    rows.insert(rows.size(), acc(KIND_READ, 32'h40));
    for (int t = 1; t <= 6; t++)
      rows.insert(rows.size(),
                  acc(t < 5 ? KIND_WRITE : KIND_READ, (32'(t) << 13) | (32'd5 << 5)));
    rows.insert(rows.size(), acc(KIND_WRITE, 32'hFFFF_FFE0));
    rows.insert(rows.size(), acc(KIND_READ, 32'h0000_0060));
    rows.insert(rows.size(), cfg_row(1'b0));
    rows.insert(rows.size(), acc(KIND_READ, 32'h1234_5678));
    rows.insert(rows.size(), acc(KIND_WRITE, 32'h8000_0000));
    rows.insert(rows.size(), acc(KIND_READ, 32'h20));
    rows.insert(rows.size(), acc(KIND_WRITE, 32'h5555_5555));
    rows.insert(rows.size(), cfg_row(1'b1));
    rows.insert(rows.size(), acc(KIND_READ, 32'h7FFF_FFE0));
    rows.insert(rows.size(), acc(KIND_WRITE, 32'hAAAA_AAAA));

    foreach (rows[i]) begin
      if (rows[i].op == ROW_CFG) write_prefetch_enable(rows[i].k);
      else send_access(rows[i].k, rows[i].a, rows[i].typed, rows[i].r);
    end

    strm_addr = $urandom;
    for (int ph = 0; ph < 3; ph++) begin
      write_prefetch_enable(ph != 1);
      tx_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 48 : 0;
      rx_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 15 : 0;
      for (int i = 0; i < 4; i++) set_pool[i] = 8'($urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 100) hold_go = 1;
        mode = $urandom_range(9);
        if (mode < 4) begin
          // sequential streams, with occasional skips and restarts
          if ($urandom_range(19) == 0) strm_addr = $urandom;
          strm_addr += 32'($urandom_range(3) == 0 ? $urandom_range(1, 3) : 1) << 5;
          a = {strm_addr[31:5], 5'($urandom)};
        end else if (mode < 7) begin
          // few tags in few sets: evictions and dirty writebacks
          tg = $urandom_range(1) ? 19'($urandom_range(7)) : 19'($urandom);
          a = {tg, set_pool[$urandom_range(3)], 5'($urandom)};
        end else begin
          a = $urandom;
        end
        send_access(1'($urandom), a, 0, '0);
      end
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    in_valid <= 1'b0;

    wait (expected_q.size() == 0);
    repeat (20) @(posedge clk);
    $display("checked %0d results: %0d stream hits, %0d dirty writebacks,",
             n_checked, n_shit, n_wb);
    $display("prefetch on and off, both idling mixes and a long receiver hold-off");
    if (errors == 0 && expected_q.size() == 0)
      $display("tb_lru_writeback_cache_with_stream_prefetch_core passed");
    else
      $display("tb_lru_writeback_cache_with_stream_prefetch_core failed");
    $finish;
  end

endmodule

FILE: lru_writeback_cache_with_stream_prefetch_core.f
sv/lwc_pkg.sv
sv/lwc_ram.sv
sv/lru_writeback_cache_with_stream_prefetch_core.sv
sim/tb_lru_writeback_cache_with_stream_prefetch_core.sv
